### sv/trcc_pkg.sv
package trcc_pkg;

  localparam int SeqWidth   = 32;
  localparam int BytesWidth = 16;
  localparam int SegsWidth  = 16;
  localparam int FlagsWidth = 4;
  localparam int TimeWidth  = 32;
  localparam int CfgWidth   = 32;

  localparam int FLAG_SYN_BIT = 0;
  localparam int FLAG_FIN_BIT = 1;
  localparam int FLAG_RST_BIT = 2;
  localparam int FLAG_PSH_BIT = 3;

  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic SRC_HELD = 1'b0;
  localparam logic SRC_PASS = 1'b1;

  localparam logic CFG_MAX_AGGREGATE_BYTES = 1'b0;
  localparam logic CFG_HOLD_TIMEOUT_US     = 1'b1;

  localparam logic [BytesWidth-1:0] MAX_BYTES_RESET = 16'hFFFF;
  localparam logic [TimeWidth-1:0]  TIMEOUT_RESET   = 32'd40000;

  localparam int QueueDepthDefault = 4;

  typedef struct packed {
    logic [SeqWidth-1:0]   seq;
    logic [SeqWidth-1:0]   ack;
    logic [BytesWidth-1:0] bytes;
    logic [SegsWidth-1:0]  segs;
    logic [FlagsWidth-1:0] flags;
  } rec_t;

  typedef struct packed {
    logic has_held;
    logic has_pass;
    rec_t held;
    rec_t pass;
  } entry_t;

endpackage

### sv/trcc_front.sv
module trcc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [trcc_pkg::CfgWidth-1:0]    cfg_data,
  input  logic                             accept,
  input  logic                             func,
  input  logic [trcc_pkg::SeqWidth-1:0]    seq_num,
  input  logic [trcc_pkg::SeqWidth-1:0]    ack_num,
  input  logic [trcc_pkg::BytesWidth-1:0]  payload_bytes,
  input  logic [trcc_pkg::FlagsWidth-1:0]  tcp_flags,
  input  logic [trcc_pkg::TimeWidth-1:0]   now_us,
  output logic                             push,
  output trcc_pkg::entry_t                 entry
);

  logic [trcc_pkg::BytesWidth-1:0] max_bytes;
  logic [trcc_pkg::TimeWidth-1:0]  timeout;

  logic                            held_valid;
  trcc_pkg::rec_t                  held;
  logic [trcc_pkg::TimeWidth-1:0]  held_stamp;

  logic                            held_valid_next;
  trcc_pkg::rec_t                  held_next;
  logic [trcc_pkg::TimeWidth-1:0]  held_stamp_next;

  logic                            ctrl_flag;
  logic                            psh;
  logic [trcc_pkg::BytesWidth:0]   merged_bytes;
  logic [trcc_pkg::SegsWidth-1:0]  merged_segs;
  logic [trcc_pkg::TimeWidth-1:0]  age;
  logic                            mergeable;
  trcc_pkg::rec_t                  arrival;
  trcc_pkg::rec_t                  merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= trcc_pkg::MAX_BYTES_RESET;
      timeout   <= trcc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        trcc_pkg::CFG_MAX_AGGREGATE_BYTES: max_bytes <= cfg_data[trcc_pkg::BytesWidth-1:0];
        trcc_pkg::CFG_HOLD_TIMEOUT_US:     timeout   <= cfg_data[trcc_pkg::TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl_flag = tcp_flags[trcc_pkg::FLAG_SYN_BIT] | tcp_flags[trcc_pkg::FLAG_FIN_BIT]
              | tcp_flags[trcc_pkg::FLAG_RST_BIT];
    psh = tcp_flags[trcc_pkg::FLAG_PSH_BIT];
    merged_bytes = {1'b0, held.bytes} + {1'b0, payload_bytes};
    if (held.segs == '0) begin
      merged_segs = trcc_pkg::SegsWidth'(2);
    end else if (held.segs == '1) begin
      merged_segs = held.segs;
    end else begin
      merged_segs = held.segs + trcc_pkg::SegsWidth'(1);
    end
    age = now_us - held_stamp;
    mergeable = (seq_num == held.seq + {{(trcc_pkg::SeqWidth-trcc_pkg::BytesWidth){1'b0}},
                                        held.bytes})
              && (ack_num == held.ack) && !psh && (merged_bytes <= {1'b0, max_bytes});

    arrival.seq   = seq_num;
    arrival.ack   = ack_num;
    arrival.bytes = payload_bytes;
    arrival.segs  = '0;
    arrival.flags = tcp_flags;

    merged       = held;
    merged.bytes = merged_bytes[trcc_pkg::BytesWidth-1:0];
    merged.segs  = merged_segs;

    held_valid_next = held_valid;
    held_next       = held;
    held_stamp_next = held_stamp;
    entry.has_held  = 1'b0;
    entry.has_pass  = 1'b0;
    entry.held      = held;
    entry.pass      = arrival;

    if (func == trcc_pkg::FUNC_TICK) begin
      if (held_valid && age >= timeout) begin
        entry.has_held  = 1'b1;
        held_valid_next = 1'b0;
      end
    end else if (ctrl_flag) begin
      if (held_valid) begin
        entry.has_held  = 1'b1;
        held_next       = arrival;
        held_stamp_next = now_us;
      end else begin
        entry.has_pass = 1'b1;
      end
    end else if (payload_bytes == '0) begin
      entry.has_held  = held_valid;
      entry.has_pass  = 1'b1;
      held_valid_next = 1'b0;
    end else if (!held_valid) begin
      if (psh) begin
        entry.has_pass = 1'b1;
      end else begin
        held_valid_next = 1'b1;
        held_next       = arrival;
        held_stamp_next = now_us;
      end
    end else if (mergeable) begin
      held_next  = merged;
      entry.held = merged;
      if (held.flags[trcc_pkg::FLAG_PSH_BIT] || merged_bytes >= {1'b0, max_bytes}) begin
        entry.has_held  = 1'b1;
        held_valid_next = 1'b0;
      end
    end else begin
      entry.has_held  = 1'b1;
      held_next       = arrival;
      held_stamp_next = now_us;
    end

    push = accept && (entry.has_held || entry.has_pass);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held       <= held_next;
      held_stamp <= held_stamp_next;
    end
  end

endmodule

### sv/trcc_queue.sv
module trcc_queue #(
  parameter int Depth = trcc_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  trcc_pkg::entry_t push_entry,
  output logic             full,
  output logic             head_valid,
  output trcc_pkg::entry_t head,
  input  logic             pop
);

  localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountWidth = $clog2(Depth + 1);

  trcc_pkg::entry_t          slots [Depth];
  logic [PtrWidth-1:0]       wr_ptr;
  logic [PtrWidth-1:0]       rd_ptr;
  logic [CountWidth-1:0]     count;
  logic                      do_push;
  logic                      do_pop;

  assign full       = (count == CountWidth'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(Depth - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(Depth - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CountWidth'(1);
      end
    end
  end

endmodule

### sv/trcc_back.sv
module trcc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  trcc_pkg::entry_t                 head,
  output logic                             pop,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             source,
  output logic [trcc_pkg::SeqWidth-1:0]    out_seq,
  output logic [trcc_pkg::SeqWidth-1:0]    out_ack,
  output logic [trcc_pkg::BytesWidth-1:0]  out_payload_bytes,
  output logic [trcc_pkg::SegsWidth-1:0]   out_segments,
  output logic [trcc_pkg::FlagsWidth-1:0]  out_flags,
  output logic                             last
);

  logic           second;
  logic           load;
  logic           take_held;
  trcc_pkg::rec_t rec;

  assign load      = head_valid && (!rsp_valid || !rsp_stall);
  assign take_held = head.has_held && !second;
  assign rec       = take_held ? head.held : head.pass;
  assign pop       = load && !(take_held && head.has_pass);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
        second    <= take_held && head.has_pass;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      source            <= take_held ? trcc_pkg::SRC_HELD : trcc_pkg::SRC_PASS;
      out_seq           <= rec.seq;
      out_ack           <= rec.ack;
      out_payload_bytes <= rec.bytes;
      out_segments      <= rec.segs;
      out_flags         <= rec.flags;
      last              <= !(take_held && head.has_pass);
    end
  end

endmodule

### sv/tcp_receive_coalescing_control_unit.sv
// TCP receive-coalescing controller for one flow, working on header descriptors.
// Each accepted transaction (packet header or timer tick) is classified in the
// cycle it is accepted and yields zero, one or two results; the held aggregate
// is updated at that same edge, so a new transaction is taken every cycle while
// the result queue has room. Results leave through a registered output at one
// per cycle while rsp_stall is low; a transaction with two results (held
// aggregate, then the arriving packet) sends them in turn. Configuration must
// be written only while idle; the block does not enforce this.
module tcp_receive_coalescing_control_unit #(
  parameter int QueueDepth = trcc_pkg::QueueDepthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [trcc_pkg::CfgWidth-1:0]    cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             func,
  input  logic [trcc_pkg::SeqWidth-1:0]    seq_num,
  input  logic [trcc_pkg::SeqWidth-1:0]    ack_num,
  input  logic [trcc_pkg::BytesWidth-1:0]  payload_bytes,
  input  logic [trcc_pkg::FlagsWidth-1:0]  tcp_flags,
  input  logic [trcc_pkg::TimeWidth-1:0]   now_us,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             source,
  output logic [trcc_pkg::SeqWidth-1:0]    out_seq,
  output logic [trcc_pkg::SeqWidth-1:0]    out_ack,
  output logic [trcc_pkg::BytesWidth-1:0]  out_payload_bytes,
  output logic [trcc_pkg::SegsWidth-1:0]   out_segments,
  output logic [trcc_pkg::FlagsWidth-1:0]  out_flags,
  output logic                             last
);

  logic             accept;
  logic             push;
  logic             full;
  logic             head_valid;
  logic             pop;
  trcc_pkg::entry_t push_entry;
  trcc_pkg::entry_t head;

  assign req_stall = full;
  assign accept    = req_valid && !full;

  trcc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .func          (func),
    .seq_num       (seq_num),
    .ack_num       (ack_num),
    .payload_bytes (payload_bytes),
    .tcp_flags     (tcp_flags),
    .now_us        (now_us),
    .push          (push),
    .entry         (push_entry)
  );

  trcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  trcc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .source            (source),
    .out_seq           (out_seq),
    .out_ack           (out_ack),
    .out_payload_bytes (out_payload_bytes),
    .out_segments      (out_segments),
    .out_flags         (out_flags),
    .last              (last)
  );

endmodule

### bench/coalesce_checker.sv
module coalesce_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [trcc_pkg::CfgWidth-1:0]    cfg_data,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic                             func,
  input  logic [trcc_pkg::SeqWidth-1:0]    seq_num,
  input  logic [trcc_pkg::SeqWidth-1:0]    ack_num,
  input  logic [trcc_pkg::BytesWidth-1:0]  payload_bytes,
  input  logic [trcc_pkg::FlagsWidth-1:0]  tcp_flags,
  input  logic [trcc_pkg::TimeWidth-1:0]   now_us,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  logic                             source,
  input  logic [trcc_pkg::SeqWidth-1:0]    out_seq,
  input  logic [trcc_pkg::SeqWidth-1:0]    out_ack,
  input  logic [trcc_pkg::BytesWidth-1:0]  out_payload_bytes,
  input  logic [trcc_pkg::SegsWidth-1:0]   out_segments,
  input  logic [trcc_pkg::FlagsWidth-1:0]  out_flags,
  input  logic                             last,
  output int                               fail_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import trcc_pkg::*;

  typedef struct packed {
    logic                  src;
    logic [SeqWidth-1:0]   seq;
    logic [SeqWidth-1:0]   ack;
    logic [BytesWidth-1:0] bytes;
    logic [SegsWidth-1:0]  segs;
    logic [FlagsWidth-1:0] flags;
    logic                  last;
  } release_t;

  release_t due_releases[$];
  release_t want;
  int mismatches = 0;

  logic [BytesWidth-1:0] limit_bytes;
  logic [TimeWidth-1:0]  limit_us;

  logic                  agg_valid;
  logic [SeqWidth-1:0]   agg_seq;
  logic [SeqWidth-1:0]   agg_ack;
  logic [BytesWidth-1:0] agg_bytes;
  logic [SegsWidth-1:0]  agg_segs;
  logic [FlagsWidth-1:0] agg_flags;
  logic [TimeWidth-1:0]  agg_stamp;

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("coalesce_checker: %0t %s mismatch, expected %h got %h",
             $realtime, field, exp_val, got_val);
    mismatches++;
  endtask

  task automatic queue_release(input logic src, input logic [SeqWidth-1:0] s,
                               input logic [SeqWidth-1:0] a,
                               input logic [BytesWidth-1:0] b,
                               input logic [SegsWidth-1:0] n,
                               input logic [FlagsWidth-1:0] f);
    release_t r;
    r = '{src: src, seq: s, ack: a, bytes: b, segs: n, flags: f, last: 1'b0};
    due_releases.push_back(r);
  endtask

  task automatic release_held();
    queue_release(SRC_HELD, agg_seq, agg_ack, agg_bytes, agg_segs, agg_flags);
    agg_valid = 1'b0;
  endtask

  task automatic start_aggregate(input logic [SeqWidth-1:0] s, input logic [SeqWidth-1:0] a,
                                 input logic [BytesWidth-1:0] b,
                                 input logic [FlagsWidth-1:0] f,
                                 input logic [TimeWidth-1:0] t);
    agg_valid = 1'b1;
    agg_seq   = s;
    agg_ack   = a;
    agg_bytes = b;
    agg_segs  = '0;
    agg_flags = f;
    agg_stamp = t;
  endtask

  task automatic coalesce_arrival(input logic fn, input logic [SeqWidth-1:0] s,
                                  input logic [SeqWidth-1:0] a,
                                  input logic [BytesWidth-1:0] b,
                                  input logic [FlagsWidth-1:0] f,
                                  input logic [TimeWidth-1:0] t);
    int first;
    first = due_releases.size();
    if (fn == FUNC_TICK) begin
      if (agg_valid && (t - agg_stamp) >= limit_us)
        release_held();
    end else if (f[FLAG_SYN_BIT] || f[FLAG_FIN_BIT] || f[FLAG_RST_BIT]) begin
      if (agg_valid) begin
        release_held();
        start_aggregate(s, a, b, f, t);
      end else begin
        queue_release(SRC_PASS, s, a, b, '0, f);
      end
    end else if (b == '0) begin
      if (agg_valid)
        release_held();
      queue_release(SRC_PASS, s, a, '0, '0, f);
    end else if (!agg_valid) begin
      if (f[FLAG_PSH_BIT])
        queue_release(SRC_PASS, s, a, b, '0, f);
      else
        start_aggregate(s, a, b, f, t);
    end else if (s == agg_seq + SeqWidth'(agg_bytes) && a == agg_ack && !f[FLAG_PSH_BIT] &&
                 ({1'b0, agg_bytes} + {1'b0, b}) <= {1'b0, limit_bytes}) begin
      agg_bytes = agg_bytes + b;
      if (agg_segs == '0)
        agg_segs = SegsWidth'(1);
      if (agg_segs != '1)
        agg_segs = agg_segs + SegsWidth'(1);
      if (agg_flags[FLAG_PSH_BIT] || agg_bytes >= limit_bytes)
        release_held();
    end else begin
      release_held();
      start_aggregate(s, a, b, f, t);
    end
    if (due_releases.size() > first)
      due_releases[due_releases.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_releases.delete();
      limit_bytes = MAX_BYTES_RESET;
      limit_us    = TIMEOUT_RESET;
      agg_valid   = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_releases.size() == 0) begin
          report_mismatch("unrequested result, seq", '0, out_seq);
        end else begin
          want = due_releases.pop_front();
          if (source !== want.src)
            report_mismatch("source", 32'(want.src), 32'(source));
          if (out_seq !== want.seq)
            report_mismatch("out_seq", want.seq, out_seq);
          if (out_ack !== want.ack)
            report_mismatch("out_ack", want.ack, out_ack);
          if (out_payload_bytes !== want.bytes)
            report_mismatch("out_payload_bytes", 32'(want.bytes), 32'(out_payload_bytes));
          if (out_segments !== want.segs)
            report_mismatch("out_segments", 32'(want.segs), 32'(out_segments));
          if (out_flags !== want.flags)
            report_mismatch("out_flags", 32'(want.flags), 32'(out_flags));
          if (last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(last));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_AGGREGATE_BYTES)
          limit_bytes = cfg_data[BytesWidth-1:0];
        else
          limit_us = cfg_data[TimeWidth-1:0];
      end
      if (req_valid && !req_stall)
        coalesce_arrival(func, seq_num, ack_num, payload_bytes, tcp_flags, now_us);
    end
    outstanding <= due_releases.size();
    fail_count  <= mismatches;
  end

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trcc_pkg::*;

  localparam logic [FlagsWidth-1:0] F_SYN = FlagsWidth'(1 << FLAG_SYN_BIT);
  localparam logic [FlagsWidth-1:0] F_FIN = FlagsWidth'(1 << FLAG_FIN_BIT);
  localparam logic [FlagsWidth-1:0] F_RST = FlagsWidth'(1 << FLAG_RST_BIT);
  localparam logic [FlagsWidth-1:0] F_PSH = FlagsWidth'(1 << FLAG_PSH_BIT);

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CfgWidth-1:0]   cfg_data;
  logic                  req_valid;
  logic                  req_stall;
  logic                  func;
  logic [SeqWidth-1:0]   seq_num;
  logic [SeqWidth-1:0]   ack_num;
  logic [BytesWidth-1:0] payload_bytes;
  logic [FlagsWidth-1:0] tcp_flags;
  logic [TimeWidth-1:0]  now_us;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic                  source;
  logic [SeqWidth-1:0]   out_seq;
  logic [SeqWidth-1:0]   out_ack;
  logic [BytesWidth-1:0] out_payload_bytes;
  logic [SegsWidth-1:0]  out_segments;
  logic [FlagsWidth-1:0] out_flags;
  logic                  last;

  int fail_count;
  int outstanding;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_served = 1'b0;

  logic [SeqWidth-1:0]  cursor;
  logic [SeqWidth-1:0]  ack_cur;
  logic [TimeWidth-1:0] wall_us;
  logic [TimeWidth-1:0] hold_us;

  tcp_receive_coalescing_control_unit dut (.*);
  coalesce_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic offer(input logic fn, input logic [SeqWidth-1:0] s,
                       input logic [SeqWidth-1:0] a, input logic [BytesWidth-1:0] b,
                       input logic [FlagsWidth-1:0] f, input logic [TimeWidth-1:0] t);
    if (!calm && $urandom_range(0, 9) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid     <= 1'b1;
    func          <= fn;
    seq_num       <= s;
    ack_num       <= a;
    payload_bytes <= b;
    tcp_flags     <= f;
    now_us        <= t;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_limits(input logic [BytesWidth-1:0] max_bytes,
                                input logic [TimeWidth-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_AGGREGATE_BYTES;
    cfg_data  <= CfgWidth'(max_bytes);
    @(posedge clk);
    cfg_index <= CFG_HOLD_TIMEOUT_US;
    cfg_data  <= CfgWidth'(timeout);
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_us = timeout;
  endtask

  task automatic run_phase(input int count);
    logic [BytesWidth-1:0] b;
    logic [FlagsWidth-1:0] f;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      wall_us += $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0:       b = BytesWidth'($urandom_range(1, 4) * 500);
        1:       b = BytesWidth'($urandom);
        default: b = BytesWidth'($urandom_range(1, 1460));
      endcase
      f = ($urandom_range(0, 9) == 0) ? F_PSH : '0;
      if (pick < 55) begin
        offer(FUNC_PACKET, cursor, ack_cur, b, f, wall_us);
        cursor += SeqWidth'(b);
      end else if (pick < 65) begin
        if ($urandom_range(0, 1) == 1)
          ack_cur += $urandom_range(1, 3000);
        offer(FUNC_PACKET, cursor, ack_cur, '0, f, wall_us);
      end else if (pick < 70) begin
        if ($urandom_range(0, 1) == 1)
          b = '0;
        offer(FUNC_PACKET, cursor, ack_cur, b, FlagsWidth'($urandom_range(1, 7)) | f, wall_us);
        cursor += SeqWidth'(b);
      end else if (pick < 82) begin
        case ($urandom_range(0, 3))
          0:       wall_us += $urandom_range(0, 100);
          1:       wall_us += hold_us;
          2:       wall_us += hold_us - 1;
          default: wall_us += $urandom;
        endcase
        offer(FUNC_TICK, $urandom, $urandom, b, FlagsWidth'($urandom), wall_us);
      end else if (pick < 90) begin
        ack_cur = $urandom;
        offer(FUNC_PACKET, cursor, ack_cur, b, f, wall_us);
        cursor += SeqWidth'(b);
      end else if (pick < 95) begin
        cursor += $urandom_range(1, 5000);
        offer(FUNC_PACKET, cursor, ack_cur, b, f, wall_us);
        cursor += SeqWidth'(b);
      end else begin
        offer(($urandom_range(0, 1) == 1) ? FUNC_TICK : FUNC_PACKET, $urandom, $urandom,
              BytesWidth'($urandom), FlagsWidth'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rsp_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        rsp_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MAX_AGGREGATE_BYTES;
    cfg_data      <= '0;
    req_valid     <= 1'b0;
    func          <= FUNC_PACKET;
    seq_num       <= '0;
    ack_num       <= '0;
    payload_bytes <= '0;
    tcp_flags     <= '0;
    now_us        <= '0;
    hold_us = TIMEOUT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    offer(FUNC_TICK,   32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0,  32'd100);
    offer(FUNC_PACKET, 32'h0000_1000, 32'h0000_5000, 16'd0,    4'h0,  32'd100);
    offer(FUNC_PACKET, 32'h0000_1000, 32'h0000_5000, 16'd0,    F_SYN, 32'd110);
    offer(FUNC_PACKET, 32'h0000_1000, 32'h0000_5000, 16'd200,  F_PSH, 32'd120);
    offer(FUNC_PACKET, 32'h0000_1000, 32'h0000_5000, 16'd100,  4'h0,  32'd130);
    offer(FUNC_PACKET, 32'h0000_1064, 32'h0000_5000, 16'd100,  4'h0,  32'd140);
    offer(FUNC_PACKET, 32'h0000_10C8, 32'h0000_5000, 16'd0,    4'h0,  32'd150);
    offer(FUNC_PACKET, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'h0020, 4'h0,  32'd160);
    offer(FUNC_PACKET, 32'h0000_0010, 32'hFFFF_FFFF, 16'h0010, 4'h0,  32'd170);
    offer(FUNC_PACKET, 32'h0000_0020, 32'h0000_0000, 16'h0010, 4'h0,  32'd180);
    offer(FUNC_PACKET, 32'h0000_9999, 32'h0000_0000, 16'h0010, 4'h0,  32'd190);
    offer(FUNC_PACKET, 32'h0000_99A9, 32'h0000_0000, 16'h0000, F_FIN, 32'd200);
    offer(FUNC_PACKET, 32'h0000_99A9, 32'h0000_0000, 16'h0040, 4'h0,  32'd210);
    offer(FUNC_TICK,   32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0,  32'd40199);
    offer(FUNC_TICK,   32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0,  32'd40200);
    offer(FUNC_PACKET, 32'h0000_2000, 32'h0000_0001, 16'h0100, 4'h0,  32'd40300);
    offer(FUNC_PACKET, 32'h0000_2100, 32'h0000_0001, 16'h0100, F_PSH, 32'd40310);
    offer(FUNC_PACKET, 32'h0000_2200, 32'h0000_0001, 16'h0100, 4'h0,  32'd40320);
    offer(FUNC_PACKET, 32'h0000_3000, 32'h0000_0001, 16'h8000, 4'h0,  32'd40330);
    offer(FUNC_PACKET, 32'h0000_B000, 32'h0000_0001, 16'h7FFF, 4'h0,  32'd40340);
    offer(FUNC_PACKET, 32'h0000_4000, 32'h0000_0002, 16'hFFFF, 4'h0,  32'd40350);
    offer(FUNC_PACKET, 32'h0001_3FFF, 32'h0000_0002, 16'h0001, 4'h0,  32'd40360);
    offer(FUNC_PACKET, 32'h0001_4000, 32'h0000_0002, 16'h0001, F_RST | F_PSH, 32'hFFFF_FF00);
    offer(FUNC_TICK,   32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0,  32'h0000_9000);
    offer(FUNC_TICK,   32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0,  32'h0000_A000);
    offer(FUNC_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF,  32'hFFFF_FFFF);
    settle();

    wall_us = $urandom;
    program_limits(16'd3000, 32'd500);
    cursor  = 32'hFFFF_F000;
    ack_cur = $urandom;
    run_phase(250);
    settle();

    hold_req = 1'b1;
    program_limits(16'd0, 32'd0);
    cursor = $urandom;
    run_phase(250);
    settle();

    program_limits(16'hFFFF, 32'hFFFF_FFFF);
    cursor = $urandom;
    run_phase(250);
    settle();

    program_limits(16'd1, 32'd1);
    cursor = $urandom;
    run_phase(250);
    settle();

    program_limits(16'd9000, 32'd100000);
    cursor = $urandom;
    run_phase(250);
    settle();

    calm = 1'b1;
    program_limits(MAX_BYTES_RESET, TIMEOUT_RESET);
    cursor = $urandom;
    run_phase(200);
    settle();

    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
